// ===== rtl/tam_pkg.sv =====
// ----------------------------------------------------------------------------
// tam_pkg: shared widths and types of the TRIAD attitude matrix unit
// Fixed-point widths of the frame lanes and the matrix merge, and the
// structs that carry one item between the pipeline sections.
// ----------------------------------------------------------------------------
package tam_pkg;

    // input component width (signed Q1.15) and result width (signed Q3.20)
    localparam int CW = 16;
    localparam int RW = 24;

    // working fraction of unit vectors (Q30)
    localparam int WORK_FRAC = 30;

    // raw cross product term (Q30 of the Q15 inputs) and its magnitude
    localparam int XW = 2 * CW + 1;
    localparam int AW = 2 * CW;
    localparam int LW = $clog2(AW);

    // the largest normalized magnitude lies in [2^29, 2^30)
    localparam int MW = WORK_FRAC;

    // norm, square root remainder and radicand
    localparam int NW = 32;
    localparam int RMW = NW + 2;
    localparam int RADW = 2 * NW;
    localparam int SQRT_CYCLES = NW / 2;

    // dividend of the unit vector divide, two quotient bits a cycle
    localparam int DW = MW + WORK_FRAC + 1;
    localparam int DIV_CYCLES = NW / 2;

    // t2, t3 and their products
    localparam int T2W = NW;
    localparam int PW = T2W + CW;
    localparam int T3W = T2W + 1;

    // matrix accumulator and rounding shift down to the output format
    localparam int ACCW = 2 * T3W + 2;
    localparam int RSH = 2 * WORK_FRAC - (RW - 4);
    localparam int P1SH = 2 * WORK_FRAC - 2 * (CW - 1);
    localparam int NUM_ENT = 9;

    // stream payload widths
    localparam int IN_W = 12 * CW;
    localparam int OUT_W = NUM_ENT * RW;

    typedef logic [2:0][CW-1:0] t_vec;

    // front section result: normalized cross product magnitudes and norm
    typedef struct packed {
        t_vec                sun;
        logic [2:0][MW-1:0]  mag;
        logic [2:0]          neg;
        logic [NW-1:0]       norm;
        logic                degen;
    } t_front;

    // lane result: the triad of one frame
    typedef struct packed {
        t_vec                sun;
        logic [2:0][T2W-1:0] t2;
        logic [2:0][T3W-1:0] t3;
        logic                degen;
    } t_lane;

    typedef logic [NUM_ENT-1:0][RW-1:0] t_rot;

endpackage

// ===== rtl/tam_norm.sv =====
// ----------------------------------------------------------------------------
// tam_norm: cross product, normalization and norm of one frame
// Forms sun x mag, scales the magnitudes so the largest lies in
// [2^29, 2^30), sums their squares and takes the floor square root,
// two root bits a cycle.
// ----------------------------------------------------------------------------
module tam_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tam_pkg::t_vec   i_sun,
    input  tam_pkg::t_vec   i_mag,
    input  logic            i_take,
    output logic            o_ready,
    output logic            o_done,
    output tam_pkg::t_front o_res
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CROSS = 8'b0000_0010,
        S_MAG   = 8'b0000_0100,
        S_LZC   = 8'b0000_1000,
        S_SHIFT = 8'b0001_0000,
        S_SQ    = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    tam_pkg::t_vec r_sun, n_sun, r_mag, n_mag;
    logic [2:0][tam_pkg::XW-1:0] r_cross, n_cross;
    logic [2:0][tam_pkg::AW-1:0] r_abs, n_abs;
    logic [tam_pkg::AW-1:0] r_max, n_max;
    logic [tam_pkg::LW-1:0] r_lead, n_lead;
    logic [2:0][tam_pkg::MW-1:0] r_nm, n_nm;
    logic [tam_pkg::RADW-1:0] r_rad, n_rad;
    logic [tam_pkg::NW-1:0] r_root, n_root;
    logic [tam_pkg::RMW-1:0] r_rem, n_rem;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_neg, n_neg;
    logic r_degen, n_degen;

    // a1*b2 - a2*b1 on signed components
    function automatic logic [tam_pkg::XW-1:0] cross_term(
        input logic [tam_pkg::CW-1:0] a, b, c, d);
        logic signed [2*tam_pkg::CW-1:0] pa, pb;
        logic signed [tam_pkg::XW-1:0] df;
        pa = $signed(a) * $signed(b);
        pb = $signed(c) * $signed(d);
        df = pa - pb;
        return df;
    endfunction

    function automatic logic [tam_pkg::AW-1:0] abs_x(input logic [tam_pkg::XW-1:0] v);
        logic [tam_pkg::XW-1:0] m;
        m = v[tam_pkg::XW-1] ? (~v + 1'b1) : v;
        return m[tam_pkg::AW-1:0];
    endfunction

    // next state and datapath
    always_comb begin
        logic [tam_pkg::AW-1:0] mx;
        logic [tam_pkg::AW+tam_pkg::MW-2:0] sh;
        logic [2*tam_pkg::MW-1:0] sq;
        logic [tam_pkg::RMW+1:0] t, trial;
        logic [tam_pkg::RMW-1:0] rem;
        logic [tam_pkg::NW-1:0] root;
        logic [tam_pkg::RADW-1:0] rad;
        n_state = r_state;
        n_sun   = r_sun;
        n_mag   = r_mag;
        n_cross = r_cross;
        n_abs   = r_abs;
        n_max   = r_max;
        n_lead  = r_lead;
        n_nm    = r_nm;
        n_rad   = r_rad;
        n_root  = r_root;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_degen = r_degen;
        mx = '0;
        sh = '0;
        sq = '0;
        t = '0;
        trial = '0;
        rem = r_rem;
        root = r_root;
        rad = r_rad;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_sun = i_sun;
                    n_mag = i_mag;
                    n_state = S_CROSS;
                end
            end
            S_CROSS: begin
                n_cross[0] = cross_term(r_sun[1], r_mag[2], r_sun[2], r_mag[1]);
                n_cross[1] = cross_term(r_sun[2], r_mag[0], r_sun[0], r_mag[2]);
                n_cross[2] = cross_term(r_sun[0], r_mag[1], r_sun[1], r_mag[0]);
                n_state = S_MAG;
            end
            S_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    n_abs[k] = abs_x(r_cross[k]);
                    n_neg[k] = r_cross[k][tam_pkg::XW-1];
                    if (n_abs[k] > mx) mx = n_abs[k];
                end
                n_max = mx;
                n_state = S_LZC;
            end
            S_LZC: begin
                // position of the leading one of the largest magnitude
                n_lead = '0;
                for (int b = 0; b < tam_pkg::AW; b++) begin
                    if (r_max[b]) n_lead = tam_pkg::LW'(b);
                end
                n_degen = (r_max == '0);
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                for (int k = 0; k < 3; k++) begin
                    sh = {r_abs[k], {(tam_pkg::MW-1){1'b0}}} >> r_lead;
                    n_nm[k] = sh[tam_pkg::MW-1:0];
                end
                n_rad = '0;
                n_cnt = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                // sum of squares, one term a cycle
                sq = r_nm[r_cnt[1:0]] * r_nm[r_cnt[1:0]];
                n_rad = r_rad + tam_pkg::RADW'(sq);
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) begin
                    n_cnt = '0;
                    n_rem = '0;
                    n_root = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // two digit-by-digit root steps
                for (int st = 0; st < 2; st++) begin
                    t = {rem, rad[tam_pkg::RADW-1 -: 2]};
                    trial = {2'b00, root, 2'b01};
                    if (t >= trial) begin
                        t = t - trial;
                        root = {root[tam_pkg::NW-2:0], 1'b1};
                    end else begin
                        root = {root[tam_pkg::NW-2:0], 1'b0};
                    end
                    rem = t[tam_pkg::RMW-1:0];
                    rad = {rad[tam_pkg::RADW-3:0], 2'b00};
                end
                n_rem = rem;
                n_root = root;
                n_rad = rad;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(tam_pkg::SQRT_CYCLES - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sun   <= n_sun;
        r_mag   <= n_mag;
        r_cross <= n_cross;
        r_abs   <= n_abs;
        r_max   <= n_max;
        r_lead  <= n_lead;
        r_nm    <= n_nm;
        r_rad   <= n_rad;
        r_root  <= n_root;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_degen <= n_degen;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_res.sun   = r_sun;
    assign o_res.mag   = r_nm;
    assign o_res.neg   = r_neg;
    assign o_res.norm  = r_root;
    assign o_res.degen = r_degen;

endmodule

// ===== rtl/tam_unit.sv =====
// ----------------------------------------------------------------------------
// tam_unit: unit vector and third triad vector of one frame
// Three restoring dividers (two quotient bits a cycle) give t2 in Q30,
// then t3 = t2 x sun is formed one component at a time and rounded.
// ----------------------------------------------------------------------------
module tam_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  tam_pkg::t_front i_res,
    input  logic            i_take,
    output logic            o_ready,
    output logic            o_done,
    output tam_pkg::t_lane  o_res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_T3MUL = 5'b00100,
        S_T3RND = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    tam_pkg::t_front r_in, n_in;
    logic [2:0][tam_pkg::NW-1:0] r_drem, n_drem, r_dq, n_dq;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;
    logic signed [tam_pkg::PW-1:0] r_p1, n_p1, r_p2, n_p2;
    logic [2:0][tam_pkg::T3W-1:0] r_t3, n_t3;
    logic [2:0][tam_pkg::T2W-1:0] t2;

    // signed unit vector from the quotients
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t2[k] = r_in.neg[k] ? (~r_dq[k] + 1'b1) : r_dq[k];
        end
    end

    always_comb begin
        logic [tam_pkg::DW-1:0] d;
        logic [tam_pkg::NW:0] t;
        logic [tam_pkg::NW-1:0] rem, q;
        logic [tam_pkg::T2W-1:0] a, c;
        logic [tam_pkg::CW-1:0] b, e;
        logic signed [tam_pkg::PW:0] w;
        logic [tam_pkg::PW:0] wm, rnd;
        logic [tam_pkg::T3W-1:0] tm;
        n_state = r_state;
        n_in    = r_in;
        n_drem  = r_drem;
        n_dq    = r_dq;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_t3    = r_t3;
        d = '0;
        t = '0;
        rem = '0;
        q = '0;
        a = '0;
        b = '0;
        c = '0;
        e = '0;
        w = '0;
        wm = '0;
        rnd = '0;
        tm = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_in = i_res;
                    // dividend mag * 2^30 + norm/2, top bits preload the remainder
                    for (int k = 0; k < 3; k++) begin
                        d = tam_pkg::DW'({i_res.mag[k], {tam_pkg::WORK_FRAC{1'b0}}})
                            + tam_pkg::DW'(i_res.norm >> 1);
                        n_drem[k] = tam_pkg::NW'(d[tam_pkg::DW-1:tam_pkg::NW]);
                        n_dq[k] = d[tam_pkg::NW-1:0];
                    end
                    n_cnt = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    rem = r_drem[k];
                    q = r_dq[k];
                    for (int st = 0; st < 2; st++) begin
                        t = {rem, q[tam_pkg::NW-1]};
                        q = {q[tam_pkg::NW-2:0], 1'b0};
                        if (t >= {1'b0, r_in.norm}) begin
                            t = t - {1'b0, r_in.norm};
                            q[0] = 1'b1;
                        end
                        rem = t[tam_pkg::NW-1:0];
                    end
                    n_drem[k] = rem;
                    n_dq[k] = q;
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(tam_pkg::DIV_CYCLES - 1)) begin
                    n_k = '0;
                    n_state = S_T3MUL;
                end
            end
            S_T3MUL: begin
                case (r_k)
                    2'd0: begin
                        a = t2[1]; b = r_in.sun[2]; c = t2[2]; e = r_in.sun[1];
                    end
                    2'd1: begin
                        a = t2[2]; b = r_in.sun[0]; c = t2[0]; e = r_in.sun[2];
                    end
                    2'd2: begin
                        a = t2[0]; b = r_in.sun[1]; c = t2[1]; e = r_in.sun[0];
                    end
                    default: begin
                        a = '0; b = '0; c = '0; e = '0;
                    end
                endcase
                n_p1 = $signed(a) * $signed(b);
                n_p2 = $signed(c) * $signed(e);
                n_state = S_T3RND;
            end
            S_T3RND: begin
                // round to Q30, ties away from zero
                w = r_p1 - r_p2;
                wm = w[tam_pkg::PW] ? (~w + 1'b1) : w;
                rnd = (wm + ((tam_pkg::PW+1)'(1) << (tam_pkg::CW - 2))) >> (tam_pkg::CW - 1);
                tm = rnd[tam_pkg::T3W-1:0];
                n_t3[r_k] = w[tam_pkg::PW] ? (~tm + 1'b1) : tm;
                n_k = r_k + 2'd1;
                n_state = (r_k == 2'd2) ? S_DONE : S_T3MUL;
            end
            S_DONE: begin
                if (i_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_drem <= n_drem;
        r_dq   <= n_dq;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_t3   <= n_t3;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_res.sun   = r_in.sun;
    assign o_res.t2    = t2;
    assign o_res.t3    = r_t3;
    assign o_res.degen = r_in.degen;

endmodule

// ===== rtl/tam_merge.sv =====
// ----------------------------------------------------------------------------
// tam_merge: rotation matrix from the body and inertial triads
// One matrix entry a cycle: three products, then exact sum, rounding to
// Q3.20 and saturation. The result sits in an output register.
// ----------------------------------------------------------------------------
module tam_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tam_pkg::t_lane i_body,
    input  tam_pkg::t_lane i_inert,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output tam_pkg::t_rot  o_rot,
    output logic           o_degen
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    localparam logic [tam_pkg::ACCW-1:0] POS_MAX = tam_pkg::ACCW'((1 << (tam_pkg::RW-1)) - 1);
    localparam logic [tam_pkg::ACCW-1:0] NEG_MAX = tam_pkg::ACCW'(1 << (tam_pkg::RW-1));
    localparam logic [tam_pkg::ACCW-1:0] HALF = tam_pkg::ACCW'(1) << (tam_pkg::RSH - 1);

    t_state r_state, n_state;
    tam_pkg::t_lane r_b, n_b, r_i, n_i;
    logic [1:0] r_row, n_row, r_col, n_col;
    logic [3:0] r_cnt, n_cnt, r_pe, n_pe;
    logic r_pv, n_pv;
    logic signed [2*tam_pkg::CW-1:0] r_p1, n_p1;
    logic signed [2*tam_pkg::T2W-1:0] r_p2, n_p2;
    logic signed [2*tam_pkg::T3W-1:0] r_p3, n_p3;
    tam_pkg::t_rot r_work, n_work, r_orot, n_orot;
    logic r_ovalid, n_ovalid, r_odegen, n_odegen;

    always_comb begin
        logic signed [tam_pkg::ACCW-1:0] acc;
        logic [tam_pkg::ACCW-1:0] mag, rnd;
        logic [tam_pkg::RW-1:0] res;
        n_state  = r_state;
        n_b      = r_b;
        n_i      = r_i;
        n_row    = r_row;
        n_col    = r_col;
        n_cnt    = r_cnt;
        n_pe     = r_pe;
        n_pv     = 1'b0;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_p3     = r_p3;
        n_work   = r_work;
        n_orot   = r_orot;
        n_odegen = r_odegen;
        n_ovalid = r_ovalid && !i_ready;

        // exact sum, round to the output format, saturate
        acc = (tam_pkg::ACCW'(r_p1) <<< tam_pkg::P1SH) + tam_pkg::ACCW'(r_p2)
              + tam_pkg::ACCW'(r_p3);
        mag = acc[tam_pkg::ACCW-1] ? (~acc + 1'b1) : acc;
        rnd = (mag + HALF) >> tam_pkg::RSH;
        if (acc[tam_pkg::ACCW-1]) begin
            res = (rnd > NEG_MAX) ? NEG_MAX[tam_pkg::RW-1:0] : (~rnd[tam_pkg::RW-1:0] + 1'b1);
        end else begin
            res = (rnd > POS_MAX) ? POS_MAX[tam_pkg::RW-1:0] : rnd[tam_pkg::RW-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_b = i_body;
                    n_i = i_inert;
                    n_row = '0;
                    n_col = '0;
                    n_cnt = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // issue entry r_cnt, retire the one issued last cycle
                if (r_cnt < 4'(tam_pkg::NUM_ENT)) begin
                    n_p1 = $signed(r_b.sun[r_row]) * $signed(r_i.sun[r_col]);
                    n_p2 = $signed(r_b.t2[r_row]) * $signed(r_i.t2[r_col]);
                    n_p3 = $signed(r_b.t3[r_row]) * $signed(r_i.t3[r_col]);
                    n_pv = 1'b1;
                    n_pe = r_cnt;
                    if (r_col == 2'd2) begin
                        n_col = '0;
                        n_row = r_row + 2'd1;
                    end else begin
                        n_col = r_col + 2'd1;
                    end
                end
                if (r_pv) n_work[r_pe] = res;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(tam_pkg::NUM_ENT)) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!r_ovalid || i_ready) begin
                    n_odegen = r_b.degen | r_i.degen;
                    n_orot = (r_b.degen | r_i.degen) ? '0 : r_work;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_i      <= n_i;
        r_row    <= n_row;
        r_col    <= n_col;
        r_cnt    <= n_cnt;
        r_pe     <= n_pe;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_p3     <= n_p3;
        r_work   <= n_work;
        r_orot   <= n_orot;
        r_odegen <= n_odegen;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_rot   = r_orot;
    assign o_degen = r_odegen;

endmodule

// ===== rtl/triad_attitude_matrix_unit.sv =====
// ----------------------------------------------------------------------------
// triad_attitude_matrix_unit: TRIAD rotation matrix from sun and field vectors
// Two frame lanes (body, inertial) build the triads; a merge section forms
// R = [t1b t2b t3b][t1i t2i t3i]^T in saturated Q3.20.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: four Q1.15 3-vectors
//  m_axis   | out       | tdata: nine Q3.20 entries, tuser: degenerate
//
// An item is accepted only while both front sections are idle. The front section
// limits how often items are accepted: it is busy longest, most of it in the square
// root (two root bits a cycle over a 64-bit radicand), and it takes no new item
// until it has handed the current one on. The dividers and the merge need fewer
// cycles. Each section hands its item on as soon as the next is free, so an item is
// accepted while earlier ones are in the dividers, the merge or the output register.
// Reset is synchronous and clears only the control state.
// ----------------------------------------------------------------------------
module triad_attitude_matrix_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // sun_body_x/y/z, sun_inertial_x/y/z, mag_body_x/y/z, mag_inertial_x/y/z
    input  logic [tam_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
    output logic [tam_pkg::OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic                      m_axis_tuser
);

    localparam int VW = 3 * tam_pkg::CW;

    logic [1:0] f_ready, f_done, u_ready, u_done;
    tam_pkg::t_front f_res [2];
    tam_pkg::t_lane u_res [2];
    logic m_ready, in_acc, f2u, u2m;
    tam_pkg::t_rot rot;

    // section handoffs: both lanes move together
    assign s_axis_tready = f_ready[0] & f_ready[1];
    assign in_acc = s_axis_tvalid & s_axis_tready;
    assign f2u = (&f_done) & (&u_ready);
    assign u2m = (&u_done) & m_ready;

    // body lane
    tam_norm u_norm_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_sun   (s_axis_tdata[VW-1:0]),
        .i_mag   (s_axis_tdata[3*VW-1:2*VW]),
        .i_take  (f2u),
        .o_ready (f_ready[0]),
        .o_done  (f_done[0]),
        .o_res   (f_res[0])
    );

    tam_unit u_unit_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (f2u),
        .i_res   (f_res[0]),
        .i_take  (u2m),
        .o_ready (u_ready[0]),
        .o_done  (u_done[0]),
        .o_res   (u_res[0])
    );

    // inertial lane
    tam_norm u_norm_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_sun   (s_axis_tdata[2*VW-1:VW]),
        .i_mag   (s_axis_tdata[4*VW-1:3*VW]),
        .i_take  (f2u),
        .o_ready (f_ready[1]),
        .o_done  (f_done[1]),
        .o_res   (f_res[1])
    );

    tam_unit u_unit_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (f2u),
        .i_res   (f_res[1]),
        .i_take  (u2m),
        .o_ready (u_ready[1]),
        .o_done  (u_done[1]),
        .o_res   (u_res[1])
    );

    // matrix merge and output register
    tam_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u2m),
        .i_body  (u_res[0]),
        .i_inert (u_res[1]),
        .o_ready (m_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rot   (rot),
        .o_degen (m_axis_tuser)
    );

    assign m_axis_tdata = rot;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the TRIAD attitude matrix unit
// Drives vector sets over the input stream with random gaps, predicts each
// rotation matrix in 64-bit fixed point and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [15:0] t_comp;

    // expected result of one item
    typedef struct {
        logic [tam_pkg::RW-1:0] rot [9];
        logic                   degen;
    } t_matrix;

    // ------------------------------------------------------------------
    // scoreboard: predicts matrices and checks them in order
    // ------------------------------------------------------------------
    class matrix_board;
        t_matrix pending[$];
        int      mismatches;
        int      checked;
        int      degen_seen;

        // nearest, ties away from zero
        static function longint round_shift(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        static function void cross3(input longint a[3], input longint b[3],
                                    output longint c[3]);
            c[0] = a[1] * b[2] - a[2] * b[1];
            c[1] = a[2] * b[0] - a[0] * b[2];
            c[2] = a[0] * b[1] - a[1] * b[0];
        endfunction

        static function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // unit vector in Q30 of a Q60 cross product; 0 when it is zero
        static function bit unit_vec(input longint c[3], output longint u[3]);
            longint unsigned m[3], mx, q, n, r;
            mx = 0;
            q = 0;
            for (int k = 0; k < 3; k++) begin
                m[k] = (c[k] < 0) ? -c[k] : c[k];
                if (m[k] > mx) mx = m[k];
            end
            if (mx == 0) return 0;
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int k = 0; k < 3; k++) m[k] >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx <<= 1;
                for (int k = 0; k < 3; k++) m[k] <<= 1;
            end
            for (int k = 0; k < 3; k++) q += m[k] * m[k];
            n = int_sqrt(q);
            for (int k = 0; k < 3; k++) begin
                r = ((m[k] << 30) + (n >> 1)) / n;
                u[k] = (c[k] < 0) ? -longint'(r) : longint'(r);
            end
            return 1;
        endfunction

        // note an accepted vector set and queue its matrix
        function void note_vectors(logic [tam_pkg::IN_W-1:0] data);
            longint sb[3], si[3], mb[3], mi[3], cb[3], ci[3];
            longint t2b[3], t2i[3], t3b[3], t3i[3], w[3];
            longint acc, r, hi, lo;
            t_matrix m;
            bit okb, oki;
            hi = (longint'(1) << (tam_pkg::RW - 1)) - 1;
            lo = -(longint'(1) << (tam_pkg::RW - 1));
            for (int i = 0; i < 3; i++) begin
                sb[i] = longint'(t_comp'(data[tam_pkg::CW*i +: tam_pkg::CW])) <<< 15;
                si[i] = longint'(t_comp'(data[tam_pkg::CW*(3+i) +: tam_pkg::CW])) <<< 15;
                mb[i] = longint'(t_comp'(data[tam_pkg::CW*(6+i) +: tam_pkg::CW])) <<< 15;
                mi[i] = longint'(t_comp'(data[tam_pkg::CW*(9+i) +: tam_pkg::CW])) <<< 15;
            end
            cross3(sb, mb, cb);
            cross3(si, mi, ci);
            okb = unit_vec(cb, t2b);
            oki = unit_vec(ci, t2i);
            m.degen = !(okb && oki);
            if (m.degen) begin
                for (int e = 0; e < 9; e++) m.rot[e] = '0;
                degen_seen++;
            end else begin
                cross3(t2b, sb, w);
                for (int k = 0; k < 3; k++) t3b[k] = round_shift(w[k], 30);
                cross3(t2i, si, w);
                for (int k = 0; k < 3; k++) t3i[k] = round_shift(w[k], 30);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        acc = sb[i] * si[j] + t2b[i] * t2i[j] + t3b[i] * t3i[j];
                        r = round_shift(acc, 60 - (tam_pkg::RW - 4));
                        if (r > hi) r = hi;
                        if (r < lo) r = lo;
                        m.rot[i*3+j] = r[tam_pkg::RW-1:0];
                    end
            end
            pending.push_back(m);
        endfunction

        // compare one result with the oldest prediction
        function void check_matrix(logic [tam_pkg::OUT_W-1:0] data, logic degen);
            t_matrix m;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", data);
                return;
            end
            m = pending.pop_front();
            checked++;
            bad = (degen !== m.degen);
            for (int e = 0; e < 9; e++)
                if (data[tam_pkg::RW*e +: tam_pkg::RW] !== m.rot[e]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d degenerate exp %b got %b",
                             checked, m.degen, degen);
                    for (int e = 0; e < 9; e++)
                        $display("  rot_%0d%0d exp %h got %h", e / 3, e % 3,
                                 m.rot[e], data[tam_pkg::RW*e +: tam_pkg::RW]);
                end
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [tam_pkg::IN_W-1:0]    s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [tam_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                        m_axis_tuser;

    matrix_board board;
    int  sent;
    bit  quiet_phase;
    bit  hold_rx;
    int  idle_cycles;

    localparam int RANDOM_ITEMS = 2000;
    localparam int WATCHDOG = 20000;

    triad_attitude_matrix_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // random vector component, biased toward extremes and small values
    function automatic logic [tam_pkg::CW-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // random vector set; some share directions or zero the body magnetic vector to hit the degenerate case
    function automatic logic [tam_pkg::IN_W-1:0] rand_set();
        logic [tam_pkg::IN_W-1:0] d;
        int sh;
        for (int k = 0; k < 12; k++) d[tam_pkg::CW*k +: tam_pkg::CW] = rand_comp();
        case ($urandom_range(0, 19))
            0: d[tam_pkg::CW*6 +: 3*tam_pkg::CW] = d[0 +: 3*tam_pkg::CW];
            1: d[tam_pkg::CW*9 +: 3*tam_pkg::CW] = d[tam_pkg::CW*3 +: 3*tam_pkg::CW];
            2: d[tam_pkg::CW*6 +: 3*tam_pkg::CW] = '0;
            3: begin
                // parallel but scaled magnetic vector
                sh = $urandom_range(1, 4);
                for (int k = 0; k < 3; k++)
                    d[tam_pkg::CW*(9+k) +: tam_pkg::CW] =
                        t_comp'(d[tam_pkg::CW*(3+k) +: tam_pkg::CW]) >>> sh;
            end
            default: ;
        endcase
        return d;
    endfunction

    // offer one item and wait for its acceptance; valid stays up between items unless a random gap is inserted
    task automatic send_set(logic [tam_pkg::IN_W-1:0] d);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_vectors(d);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [tam_pkg::IN_W-1:0] pack_set(t_comp v[12]);
        logic [tam_pkg::IN_W-1:0] d;
        for (int k = 0; k < 12; k++) d[tam_pkg::CW*k +: tam_pkg::CW] = v[k];
        return d;
    endfunction

    // receiver: random stalls, one long hold, none in the quiet phase
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_rx = 0;
                m_axis_tready <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_matrix(m_axis_tdata, m_axis_tuser);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_comp v[12];
        board = new();
        sent = 0;
        idle_cycles = 0;
        quiet_phase = 0;
        hold_rx = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity frames, extremes, degenerate sets
        v = '{16'sh4000, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 16'sh4000, 0};
        send_set(pack_set(v));
        v = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000};
        send_set(pack_set(v));
        v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000,
              -16'sh8000, 16'sh7fff, 0, 16'sh7fff, -16'sh8000, 0};
        send_set(pack_set(v));
        for (int k = 0; k < 12; k++) v[k] = -16'sh8000;
        v[7] = 16'sh7fff; v[10] = 0;
        send_set(pack_set(v));
        send_set('0);
        send_set({tam_pkg::IN_W{1'b1}});
        v = '{16'sh1234, -16'sh2000, 16'sh0100, 16'sh0001, 0, 0,
              16'sh1234, -16'sh2000, 16'sh0100, 0, 16'sh0001, 0};
        send_set(pack_set(v));
        v = '{1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1};
        send_set(pack_set(v));
        v = '{16'sh7fff, 0, 0, 16'sh7fff, 0, 0, 0, 0, 16'sh0001, 0, 0, -16'sh8000};
        send_set(pack_set(v));
        for (int n = 0; n < 8; n++) send_set({tam_pkg::IN_W/32{$urandom}});

        // random part with a long receiver hold partway through
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_rx = 1;
            if (n == RANDOM_ITEMS - 200) quiet_phase = 1;
            send_set(rand_set());
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("sent %0d vector sets, checked %0d matrices, %0d degenerate",
                 sent, board.checked, board.degen_seen);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
